### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define CFD_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("command frame decoder assertion failed");

// antecedent implies consequent in the same cycle
`define CFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("command frame decoder assertion failed");

// antecedent implies consequent on the next clock edge
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("command frame decoder assertion failed");

`endif

### design/cfd_pkg.sv
// types and constants of the command frame decoder
`timescale 1ns / 1ps

package cfd_pkg;

   localparam int PAYLOAD_DEPTH = 6;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADLEN = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;
   localparam logic [1:0] ST_UNSUP  = 2'd3;

   // action codes
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_SHOW   = 3'd1;
   localparam logic [2:0] ACT_RESET  = 3'd2;
   localparam logic [2:0] ACT_SHIP   = 3'd3;
   localparam logic [2:0] ACT_STRIDE = 3'd4;
   localparam logic [2:0] ACT_TIME   = 3'd5;

   // opcodes
   localparam logic [7:0] OP_SHOW   = 8'd1;
   localparam logic [7:0] OP_RESET  = 8'd2;
   localparam logic [7:0] OP_SHIP   = 8'd3;
   localparam logic [7:0] OP_STRIDE = 8'd4;
   localparam logic [7:0] OP_TIME   = 8'd5;

   // required frame lengths, and the limit at which the byte count saturates
   localparam logic [3:0] LEN_SHORT  = 4'd1;
   localparam logic [3:0] LEN_STRIDE = 4'd3;
   localparam logic [3:0] LEN_TIME   = 4'd7;
   localparam logic [3:0] COUNT_MAX  = 4'd15;

   // range limits
   localparam logic [31:0]        STRIDE_MIN = 32'd100;
   localparam logic [31:0]        STRIDE_MAX = 32'd2000;
   localparam logic [31:0]        EPOCH_MIN  = 32'd1577836800;
   localparam logic signed [15:0] ZONE_MIN   = -16'sd720;
   localparam logic signed [15:0] ZONE_MAX   = 16'sd840;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         action;
      logic [31:0]        value;
      logic signed [15:0] zone_minutes;
   } rsp_word_type;

   typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_type;

   // one finished frame, handed from front to back
   typedef struct packed {
      logic [7:0]  opcode;
      logic [3:0]  length;
      payload_type payload;
   } frame_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### design/cfd_front.sv
// byte collector: counts bytes, keeps opcode and payload, emits finished frames
`timescale 1ns / 1ps

module cfd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cfd_pkg::req_word_type     req_word,
   input  cfd_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output cfd_pkg::frame_type        push_frame
);

   logic [3:0]           count_ff, count_in;
   logic [7:0]           opcode_ff, opcode_in;
   cfd_pkg::payload_type payload_ff, payload_in;
   logic [3:0]           count_sat;
   logic                 accept;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign count_sat = (count_ff == cfd_pkg::COUNT_MAX) ? count_ff : count_ff + 4'd1;

   always_comb begin
      payload_in = payload_ff;
      for (int i = 0; i < cfd_pkg::PAYLOAD_DEPTH; i++) begin
         if (count_ff == 4'(i + 1)) begin
            payload_in[i] = req_word.data_byte;
         end
      end
      opcode_in = (count_ff == 4'd0) ? req_word.data_byte : opcode_ff;
      count_in  = req_word.last_byte ? 4'd0 : count_sat;
   end

   assign push_valid         = req_valid && req_word.last_byte;
   assign push_frame.opcode  = opcode_in;
   assign push_frame.length  = count_sat;
   assign push_frame.payload = payload_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 4'd0;
         opcode_ff <= 8'd0;
      end else if (accept) begin
         count_ff  <= count_in;
         opcode_ff <= opcode_in;
      end
   end

   // payload bytes are only read back within the frame that wrote them
   always_ff @(posedge clock) begin
      if (accept) begin
         payload_ff <= payload_in;
      end
   end

endmodule

### design/cfd_queue.sv
// short frame queue between collector and decoder
`timescale 1ns / 1ps

module cfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  cfd_pkg::frame_type        push_frame,
   input  logic                      pop_ready,
   output logic                      pop_valid,
   output cfd_pkg::frame_type        pop_frame,
   output cfd_pkg::queue_status_type queue_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cfd_pkg::frame_type entries_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               do_push, do_pop;

   assign queue_status.full  = (fill_ff == CW'(DEPTH));
   assign queue_status.empty = (fill_ff == '0);
   assign pop_valid          = !queue_status.empty;
   assign pop_frame          = entries_ff[rd_ptr_ff];
   assign do_push            = push_valid && !queue_status.full;
   assign do_pop             = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

### design/cfd_back.sv
// frame decoder and result register
`timescale 1ns / 1ps

module cfd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  cfd_pkg::frame_type    pop_frame,
   output logic                  pop_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cfd_pkg::rsp_word_type rsp_word
);

   logic                  rsp_valid_ff, rsp_valid_in;
   cfd_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic [31:0]           stride;
   logic [31:0]           epoch;
   logic signed [15:0]    zone;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign stride    = {16'd0, pop_frame.payload[1], pop_frame.payload[0]};
   assign epoch     = {pop_frame.payload[3], pop_frame.payload[2],
                       pop_frame.payload[1], pop_frame.payload[0]};
   assign zone      = {pop_frame.payload[5], pop_frame.payload[4]};

   always_comb begin
      rsp_word_in = '0;
      unique case (pop_frame.opcode)
         cfd_pkg::OP_SHOW, cfd_pkg::OP_RESET, cfd_pkg::OP_SHIP: begin
            if (pop_frame.length != cfd_pkg::LEN_SHORT) begin
               rsp_word_in.status = cfd_pkg::ST_BADLEN;
            end else begin
               rsp_word_in.status = cfd_pkg::ST_OK;
               // these opcodes equal their action codes
               rsp_word_in.action = pop_frame.opcode[2:0];
            end
         end
         cfd_pkg::OP_STRIDE: begin
            if (pop_frame.length != cfd_pkg::LEN_STRIDE) begin
               rsp_word_in.status = cfd_pkg::ST_BADLEN;
            end else begin
               rsp_word_in.value = stride;
               if (stride < cfd_pkg::STRIDE_MIN || stride > cfd_pkg::STRIDE_MAX) begin
                  rsp_word_in.status = cfd_pkg::ST_RANGE;
               end else begin
                  rsp_word_in.status = cfd_pkg::ST_OK;
                  rsp_word_in.action = cfd_pkg::ACT_STRIDE;
               end
            end
         end
         cfd_pkg::OP_TIME: begin
            if (pop_frame.length != cfd_pkg::LEN_TIME) begin
               rsp_word_in.status = cfd_pkg::ST_BADLEN;
            end else begin
               rsp_word_in.value        = epoch;
               rsp_word_in.zone_minutes = zone;
               if (epoch < cfd_pkg::EPOCH_MIN || zone < cfd_pkg::ZONE_MIN ||
                   zone > cfd_pkg::ZONE_MAX) begin
                  rsp_word_in.status = cfd_pkg::ST_RANGE;
               end else begin
                  rsp_word_in.status = cfd_pkg::ST_OK;
                  rsp_word_in.action = cfd_pkg::ACT_TIME;
               end
            end
         end
         default: begin
            rsp_word_in.status = cfd_pkg::ST_UNSUP;
         end
      endcase
   end

   assign rsp_valid_in = pop_ready ? pop_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### design/command_frame_decoder.sv
// top level of the command frame decoder
`timescale 1ns / 1ps

// command frame decoder: takes one frame byte per req word, the first byte of a
// frame being the opcode and the word with last_byte set closing the frame. a
// byte is taken every cycle while the frame queue has room, so frames stream at
// full rate; each closed frame gives exactly one rsp word, which passes through the
// queue and then the result register. other bytes give no word. the queue holds
// QUEUE_DEPTH finished frames behind the result register, so a stalled rsp side
// stops req only once QUEUE_DEPTH + 1 results wait.
// status is ok, bad length, out of range or unsupported opcode; on a range
// error the decoded value and zone are kept and the action is none
module command_frame_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cfd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cfd_pkg::rsp_word_type rsp_word
);

   // front to queue
   logic                      push_valid;
   cfd_pkg::frame_type        push_frame;
   cfd_pkg::queue_status_type queue_status;

   // queue to back
   logic                      pop_valid;
   logic                      pop_ready;
   cfd_pkg::frame_type        pop_frame;

   // byte counting, opcode and payload capture
   cfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_frame   (push_frame)
   );

   // finished frames wait here so either side can stall alone
   cfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_frame   (push_frame),
      .pop_ready    (pop_ready),
      .pop_valid    (pop_valid),
      .pop_frame    (pop_frame),
      .queue_status (queue_status)
   );

   // length and range checks, result register
   cfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_frame (pop_frame),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

### design/cfd_checker.sv
// port checker for the command frame decoder and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input cfd_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input cfd_pkg::rsp_word_type rsp_word
);

   logic req_hold;
   logic rsp_hold;
   logic action_matches;
   logic rsp_fail;
   logic fail_zero;
   logic rsp_stride;
   logic stride_in_range;

   assign req_hold        = req_valid && !req_ready;
   assign rsp_hold        = rsp_valid && !rsp_ready;
   // an action is given exactly when the status is ok
   assign action_matches  = (rsp_word.status == cfd_pkg::ST_OK) ==
                            (rsp_word.action != cfd_pkg::ACT_NONE);
   assign rsp_fail        = rsp_valid && ((rsp_word.status == cfd_pkg::ST_BADLEN) ||
                                          (rsp_word.status == cfd_pkg::ST_UNSUP));
   assign fail_zero       = (rsp_word.value == '0) && (rsp_word.zone_minutes == 16'sd0);
   assign rsp_stride      = rsp_valid && (rsp_word.action == cfd_pkg::ACT_STRIDE);
   assign stride_in_range = (rsp_word.value >= cfd_pkg::STRIDE_MIN) &&
                            (rsp_word.value <= cfd_pkg::STRIDE_MAX) &&
                            (rsp_word.zone_minutes == 16'sd0);

   `CFD_ASSERT_NEXT(a_req_hold, clock, reset, req_hold, req_valid && $stable(req_word))
   `CFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_word))
   `CFD_ASSERT_IMPLY(a_action_iff_ok, clock, reset, rsp_valid, action_matches)
   `CFD_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_fail, fail_zero)
   `CFD_ASSERT_IMPLY(a_stride_bounds, clock, reset, rsp_stride, stride_in_range)

endmodule

bind command_frame_decoder cfd_checker u_checker (.*);

### dv/tb_top.sv
// self-checking testbench for the command frame decoder
`timescale 1ns / 1ps

module tb_top;

   typedef logic [7:0] byte_list_type [$];

   localparam int ITEM_TARGET = 1050;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   cfd_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   cfd_pkg::rsp_word_type rsp_word;

   // predictor copy of the frame state
   logic [3:0]            frame_len;
   logic [7:0]            frame_op;
   cfd_pkg::payload_type  frame_payload;

   cfd_pkg::rsp_word_type pending_decodes [$];
   int                    bytes_sent;
   int                    mismatch_count;
   bit                    gaps_on;
   int                    rsp_hold_cycles;

   command_frame_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // expected word for a closed frame of len bytes
   function automatic cfd_pkg::rsp_word_type decode_frame(input logic [7:0] op,
                                                          input logic [3:0] len,
                                                          input cfd_pkg::payload_type pl);
      cfd_pkg::rsp_word_type r;
      logic [31:0]           v;
      logic signed [15:0]    z;
      r = '0;
      case (op)
         cfd_pkg::OP_SHOW, cfd_pkg::OP_RESET, cfd_pkg::OP_SHIP: begin
            if (len != cfd_pkg::LEN_SHORT) begin
               r.status = cfd_pkg::ST_BADLEN;
            end else begin
               r.status = cfd_pkg::ST_OK;
               case (op)
                  cfd_pkg::OP_SHOW:  r.action = cfd_pkg::ACT_SHOW;
                  cfd_pkg::OP_RESET: r.action = cfd_pkg::ACT_RESET;
                  default:           r.action = cfd_pkg::ACT_SHIP;
               endcase
            end
         end
         cfd_pkg::OP_STRIDE: begin
            if (len != cfd_pkg::LEN_STRIDE) begin
               r.status = cfd_pkg::ST_BADLEN;
            end else begin
               v = {16'd0, pl[1], pl[0]};
               r.value = v;
               if (v < cfd_pkg::STRIDE_MIN || v > cfd_pkg::STRIDE_MAX) begin
                  r.status = cfd_pkg::ST_RANGE;
                  r.action = cfd_pkg::ACT_NONE;
               end else begin
                  r.status = cfd_pkg::ST_OK;
                  r.action = cfd_pkg::ACT_STRIDE;
               end
            end
         end
         cfd_pkg::OP_TIME: begin
            if (len != cfd_pkg::LEN_TIME) begin
               r.status = cfd_pkg::ST_BADLEN;
            end else begin
               v = {pl[3], pl[2], pl[1], pl[0]};
               z = {pl[5], pl[4]};
               r.value = v;
               r.zone_minutes = z;
               if (v < cfd_pkg::EPOCH_MIN || z < cfd_pkg::ZONE_MIN ||
                   z > cfd_pkg::ZONE_MAX) begin
                  r.status = cfd_pkg::ST_RANGE;
                  r.action = cfd_pkg::ACT_NONE;
               end else begin
                  r.status = cfd_pkg::ST_OK;
                  r.action = cfd_pkg::ACT_TIME;
               end
            end
         end
         default: r.status = cfd_pkg::ST_UNSUP;
      endcase
      return r;
   endfunction

   // update the frame state with one accepted byte
   task automatic absorb_byte(input cfd_pkg::req_word_type w);
      if (frame_len == 4'd0) begin
         frame_op = w.data_byte;
      end else if (frame_len <= cfd_pkg::PAYLOAD_DEPTH) begin
         frame_payload[frame_len - 4'd1] = w.data_byte;
      end
      if (frame_len != cfd_pkg::COUNT_MAX) begin
         frame_len = frame_len + 4'd1;
      end
      if (w.last_byte) begin
         pending_decodes.push_back(decode_frame(frame_op, frame_len, frame_payload));
         frame_len = 4'd0;
      end
   endtask

   // called at a rising edge; returns at the edge where the byte is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int                    gap;
      cfd_pkg::req_word_type w;
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      w.data_byte = b;
      w.last_byte = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_byte(w);
      bytes_sent++;
   endtask

   task automatic send_frame(input byte_list_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   function automatic byte_list_type stride_frame(input logic [15:0] stride);
      byte_list_type f;
      f = '{cfd_pkg::OP_STRIDE, stride[7:0], stride[15:8]};
      return f;
   endfunction

   function automatic byte_list_type time_frame(input logic [31:0] epoch,
                                                input logic [15:0] zone);
      byte_list_type f;
      f = '{cfd_pkg::OP_TIME, epoch[7:0], epoch[15:8], epoch[23:16], epoch[31:24],
            zone[7:0], zone[15:8]};
      return f;
   endfunction

   // opcode followed by random bytes up to len
   function automatic byte_list_type filled_frame(input logic [7:0] op, input int len);
      byte_list_type f;
      f.push_back(op);
      for (int i = 1; i < len; i++) f.push_back(8'($urandom_range(0, 255)));
      return f;
   endfunction

   function automatic int draw_length();
      // mostly short, now and then past saturation
      return ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 8);
   endfunction

   task automatic test_short_opcodes();
      send_frame('{cfd_pkg::OP_SHOW});
      send_frame('{cfd_pkg::OP_RESET});
      send_frame('{cfd_pkg::OP_SHIP});
      send_frame('{8'd0});
      send_frame('{8'd255});
      send_frame('{cfd_pkg::OP_RESET, 8'd0});
   endtask

   task automatic test_stride_bounds();
      send_frame(stride_frame(16'(cfd_pkg::STRIDE_MAX)));
      send_frame(stride_frame(16'(cfd_pkg::STRIDE_MIN - 1)));
   endtask

   task automatic test_time_bounds();
      send_frame(time_frame(cfd_pkg::EPOCH_MIN, 16'(cfd_pkg::ZONE_MIN)));
      send_frame(time_frame(32'hFFFF_FFFF, 16'(cfd_pkg::ZONE_MAX + 16'sd1)));
   endtask

   // receiver stops for a long stretch so the frame queue fills and req stalls
   task automatic test_output_stall();
      gaps_on = 1'b0;
      rsp_hold_cycles = 80;
      repeat (24) send_frame('{cfd_pkg::OP_SHOW});
      gaps_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int          pick;
      int          len;
      int          frames;
      logic [7:0]  op;
      logic [15:0] stride;
      logic [31:0] epoch;
      logic [15:0] zone;
      frames = 0;
      while (bytes_sent < ITEM_TARGET) begin
         if (frames % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         frames++;
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            op = 8'($urandom_range(cfd_pkg::OP_SHOW, cfd_pkg::OP_SHIP));
            send_frame('{op});
         end else if (pick < 35) begin
            case ($urandom_range(0, 3))
               0: stride = 16'($urandom_range(0, 16'hFFFF));
               1: stride = 16'(cfd_pkg::STRIDE_MIN - 2 + $urandom_range(0, 4));
               2: stride = 16'(cfd_pkg::STRIDE_MAX - 2 + $urandom_range(0, 4));
               default: stride = 16'($urandom_range(cfd_pkg::STRIDE_MIN,
                                                    cfd_pkg::STRIDE_MAX));
            endcase
            send_frame(stride_frame(stride));
         end else if (pick < 60) begin
            case ($urandom_range(0, 3))
               0: epoch = $urandom();
               1: epoch = cfd_pkg::EPOCH_MIN - 2 + $urandom_range(0, 4);
               2: epoch = 32'd0;
               default: epoch = $urandom_range(cfd_pkg::EPOCH_MIN, 32'hFFFF_FFFF);
            endcase
            case ($urandom_range(0, 3))
               0: zone = 16'($urandom_range(0, 16'hFFFF));
               1: zone = 16'(cfd_pkg::ZONE_MIN) - 16'd2 + 16'($urandom_range(0, 4));
               2: zone = 16'(cfd_pkg::ZONE_MAX) - 16'd2 + 16'($urandom_range(0, 4));
               default: zone = 16'($urandom_range(0, 1560)) + 16'(cfd_pkg::ZONE_MIN);
            endcase
            send_frame(time_frame(epoch, zone));
         end else if (pick < 75) begin
            // known opcode with a wrong length
            op = 8'($urandom_range(cfd_pkg::OP_SHOW, cfd_pkg::OP_TIME));
            len = draw_length();
            if ((op == cfd_pkg::OP_STRIDE && len == cfd_pkg::LEN_STRIDE) ||
                (op == cfd_pkg::OP_TIME && len == cfd_pkg::LEN_TIME) ||
                (op <= cfd_pkg::OP_SHIP && len == cfd_pkg::LEN_SHORT)) begin
               len++;
            end
            send_frame(filled_frame(op, len));
         end else if (pick < 90) begin
            op = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(6, 255));
            send_frame(filled_frame(op, draw_length()));
         end else begin
            send_frame(filled_frame(8'($urandom_range(0, 255)), draw_length()));
         end
      end
   endtask

   // result side: a random stall before each word, or a long hold on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = gaps_on ? $urandom_range(0, 9) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cfd_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decodes.size() == 0) begin
            $error("word with nothing pending: status %0d action %0d value %0h zone %0d",
                   rsp_word.status, rsp_word.action, rsp_word.value, rsp_word.zone_minutes);
            mismatch_count++;
         end else begin
            want = pending_decodes.pop_front();
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               mismatch_count++;
            end
            if (rsp_word.action !== want.action) begin
               $error("action: expected %0d, got %0d", want.action, rsp_word.action);
               mismatch_count++;
            end
            if (rsp_word.value !== want.value) begin
               $error("value: expected %0h, got %0h", want.value, rsp_word.value);
               mismatch_count++;
            end
            if (rsp_word.zone_minutes !== want.zone_minutes) begin
               $error("zone_minutes: expected %0d, got %0d", want.zone_minutes,
                      rsp_word.zone_minutes);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      frame_len = 4'd0;
      frame_op = 8'd0;
      bytes_sent = 0;
      mismatch_count = 0;
      gaps_on = 1'b1;
      rsp_hold_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_opcodes();
      test_stride_bounds();
      test_time_bounds();
      test_output_stall();
      test_random_frames();

      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
